// File: rtl/mts_pkg.sv
`default_nettype none

package mts_pkg;

  // default sizes
  localparam int unsigned MaxTonesDefault  = 256;
  localparam int unsigned NoteCountDefault = 60;

  // field widths
  localparam int unsigned NoteW  = 8;
  localparam int unsigned WaitW  = 8;
  localparam int unsigned PtrW   = 8;
  localparam int unsigned FreqW  = 11;
  localparam int unsigned DurW   = 24;
  localparam int unsigned VolW   = 8;
  localparam int unsigned CmwW   = 4;
  localparam int unsigned CfgW   = 9;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 48;

  // special note codes
  localparam logic [NoteW-1:0] CodeEnd   = 8'hFE;
  localparam logic [NoteW-1:0] CodeEmpty = 8'hFF;
  localparam logic [NoteW-1:0] RomNotes  = 8'd60;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgToneCount  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTicksWait  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInstrument = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgVolume     = 2'd3;

  // note frequency table, padded with zeros to a power of two
  localparam logic [FreqW-1:0] NOTE_ROM [64] = '{
    11'd65,   11'd70,   11'd75,   11'd80,   11'd85,   11'd90,   11'd95,   11'd100,
    11'd105,  11'd110,  11'd115,  11'd125,  11'd130,  11'd140,  11'd150,  11'd160,
    11'd170,  11'd180,  11'd190,  11'd200,  11'd210,  11'd220,  11'd230,  11'd250,
    11'd260,  11'd280,  11'd290,  11'd310,  11'd330,  11'd350,  11'd370,  11'd390,
    11'd410,  11'd440,  11'd460,  11'd490,  11'd520,  11'd550,  11'd600,  11'd620,
    11'd660,  11'd700,  11'd750,  11'd780,  11'd840,  11'd880,  11'd940,  11'd980,
    11'd1050, 11'd1110, 11'd1170, 11'd1240, 11'd1320, 11'd1400, 11'd1480, 11'd1570,
    11'd1660, 11'd1760, 11'd1860, 11'd1980, 11'd0,    11'd0,    11'd0,    11'd0
  };

  function automatic logic [FreqW-1:0] note_freq(input logic [NoteW-1:0] note);
    logic [FreqW-1:0] f;
    f = 11'd0;
    if (note < RomNotes) begin
      f = NOTE_ROM[note[5:0]];
    end
    return f;
  endfunction

  // value mod 9 by reciprocal multiply, exact for all 8-bit values
  function automatic logic [3:0] mod_nine(input logic [7:0] v);
    logic [13:0] prod;
    logic [4:0]  quo;
    logic [7:0]  rem;
    prod = {6'd0, v} * 14'd57;
    quo  = prod[13:9];
    rem  = v - ({quo, 3'b000} + {3'b000, quo});
    return rem[3:0];
  endfunction

  // channel | (mode << 2) for each instrument
  function automatic logic [CmwW-1:0] instr_word(input logic [3:0] ins);
    logic [CmwW-1:0] w;
    case (ins)
      4'd0:    w = 4'd2;
      4'd1:    w = 4'd8;
      4'd2:    w = 4'd12;
      4'd3:    w = 4'd4;
      4'd4:    w = 4'd0;
      4'd5:    w = 4'd9;
      4'd6:    w = 4'd13;
      4'd7:    w = 4'd5;
      4'd8:    w = 4'd1;
      default: w = 4'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: rtl/music_track_sequencer.sv
`default_nettype none

// Note sequencer for a sound chip. Load transfers (tuser = 1) write a
// (note code, wait) pair into the tone store; tick transfers (tuser = 0)
// advance playback. A tick with a nonzero wait count only counts down; a
// tick at wait zero reads the entry at the playback pointer, emits one tone
// command if the code is a note, steps the pointer (wrapping at tone_count,
// or back to 0 on the end code) and reloads the wait count from the entry.
// The block takes one transfer per clock unless input is held off. A tick
// that reads the store passes the store read register and then the output
// register before its tone command shows on the master side. Pointer and
// wait count for the next tick are forwarded from the read data, so a tick
// can be taken while the last read is in flight. Input is held off only
// while a read tone command cannot enter a full, stalled output register.
// The store has no reset; entries must be loaded before playback reaches
// them. The user must write cfg_* configuration while idle; not enforced.
module music_track_sequencer
  import mts_pkg::*;
#(
  parameter int unsigned MAX_TONES  = MaxTonesDefault,
  parameter int unsigned NOTE_COUNT = NoteCountDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // slave side
  input  wire logic                s_axis_tvalid,
  output      logic                s_axis_tready,
  // entry_index [7:0], note_code [15:8], wait_ticks [23:16]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // mode [0]: 0 tick, 1 load
  input  wire logic                s_axis_tuser,
  // master side
  output      logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // frequency [10:0], duration_word [34:11], volume [42:35],
  // channel_mode_word [46:43], zero [47]
  output      logic [OutDataW-1:0] m_axis_tdata,
  // configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgW-1:0]     cfg_data_i
);

  // store depth is bounded by the 8-bit entry index
  localparam int unsigned Depth = (MAX_TONES < 256) ? MAX_TONES : 256;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [8:0]  DepthW = 9'(Depth);
  localparam logic [8:0]  NoteLimit = 9'(NOTE_COUNT);

  // configuration registers
  logic [CfgW-1:0] tone_count_q;
  logic [7:0]      ticks_q;
  logic [3:0]      instr_q;   // instrument already reduced mod 9
  logic [VolW-1:0] volume_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_count_q <= 9'd1;
      ticks_q      <= 8'd0;
      instr_q      <= 4'd0;
      volume_q     <= 8'd100;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgToneCount:  tone_count_q <= cfg_data_i;
        CfgTicksWait:  ticks_q      <= cfg_data_i[7:0];
        CfgInstrument: instr_q      <= mod_nine(cfg_data_i[7:0]);
        CfgVolume:     volume_q     <= cfg_data_i[7:0];
        default:       ;
      endcase
    end
  end

  // input fields
  logic [7:0]       in_index;
  logic [NoteW-1:0] in_note;
  logic [WaitW-1:0] in_wait;
  assign in_index = s_axis_tdata[7:0];
  assign in_note  = s_axis_tdata[15:8];
  assign in_wait  = s_axis_tdata[23:16];

  // playback state
  logic [PtrW-1:0]  ptr_q, ptr_d;
  logic [WaitW-1:0] wait_q, wait_d;
  // read stage: a tick whose store read is in flight
  logic             s1_q, s1_d;
  logic             s1_oob_q, s1_oob_d;   // pointer beyond the store
  logic [15:0]      rd_data_q;

  // output register
  logic                m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q;

  // read result, with out-of-store pointers reading as empty
  logic [NoteW-1:0] rd_note;
  logic [WaitW-1:0] rd_wait;
  logic             note_hit;
  assign rd_note  = s1_oob_q ? CodeEmpty : rd_data_q[7:0];
  assign rd_wait  = s1_oob_q ? 8'd0 : rd_data_q[15:8];
  assign note_hit = ({1'b0, rd_note} < NoteLimit);

  logic out_free, s1_stall;
  assign out_free = !m_valid_q || m_axis_tready;
  assign s1_stall = s1_q && note_hit && !out_free;
  assign s_axis_tready = !s1_stall;

  // pointer step after the read in flight
  logic [8:0]      ptr_inc;
  logic [PtrW-1:0] ptr_step;
  always_comb begin
    ptr_inc  = {1'b0, ptr_q} + 9'd1;
    ptr_step = (ptr_inc >= tone_count_q) ? 8'd0 : ptr_inc[7:0];
    if (rd_note == CodeEnd) begin
      ptr_step = 8'd0;
    end
  end

  // forwarded state as seen by the transfer in this cycle
  logic [PtrW-1:0]  cur_ptr;
  logic [WaitW-1:0] cur_wait;
  assign cur_ptr  = s1_q ? ptr_step : ptr_q;
  assign cur_wait = s1_q ? rd_wait : wait_q;

  logic accept, tick, load, rd_issue, cur_in_store;
  assign accept       = s_axis_tvalid && s_axis_tready;
  assign tick         = accept && !s_axis_tuser;
  assign load         = accept && s_axis_tuser;
  assign rd_issue     = tick && (cur_wait == 8'd0);
  assign cur_in_store = ({1'b0, cur_ptr} < DepthW);

  always_comb begin
    ptr_d    = ptr_q;
    wait_d   = wait_q;
    s1_d     = s1_q;
    s1_oob_d = s1_oob_q;
    if (!s1_stall) begin
      ptr_d    = cur_ptr;
      wait_d   = cur_wait;
      s1_d     = rd_issue;
      s1_oob_d = !cur_in_store;
      if (tick && (cur_wait != 8'd0)) begin
        wait_d = cur_wait - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      wait_q   <= '0;
      s1_q     <= 1'b0;
      s1_oob_q <= 1'b0;
    end else begin
      ptr_q    <= ptr_d;
      wait_q   <= wait_d;
      s1_q     <= s1_d;
      s1_oob_q <= s1_oob_d;
    end
  end

  // tone store: one write port for loads, one registered read port for ticks
  logic [15:0] tone_store_q [Depth];

  always_ff @(posedge clk_i) begin
    if (load && ({1'b0, in_index} < DepthW)) begin
      tone_store_q[in_index[AddrW-1:0]] <= {in_wait, in_note};
    end
  end

  // read data holds while the read stage is stalled
  always_ff @(posedge clk_i) begin
    if (rd_issue && cur_in_store) begin
      rd_data_q <= tone_store_q[cur_ptr[AddrW-1:0]];
    end
  end

  // tone command assembly
  logic [15:0] release_len;
  assign release_len = {8'd0, rd_wait} * {8'd0, ticks_q};

  logic load_out;
  assign load_out = s1_q && note_hit && out_free;

  always_comb begin
    m_valid_d = m_valid_q;
    if (load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {1'b0, instr_word(instr_q), volume_q, release_len, 8'd0,
                   note_freq(rd_note)};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

// File: rtl/mts_checker.sv
`default_nettype none

module mts_checker
  import mts_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tvalid,
  input wire logic                s_axis_tready,
  input wire logic                s_axis_tuser,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  // a stalled tone command holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("tone command changed while stalled");

  // frequency stays within the note table
  a_freq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[10:0] <= 11'd1980))
    else $error("frequency out of range");

  // duration is a multiple of 256 and the channel/mode word is an instrument code
  a_word_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[18:11] == 8'd0) && (m_axis_tdata[44:43] != 2'd3)
      && (!m_axis_tdata[44] || (m_axis_tdata[46:45] == 2'd0))))
    else $error("malformed tone command");

  // a new tone command follows an accepted tick transfer
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && !s_axis_tuser, 2))
    else $error("tone command without a tick");

endmodule

bind music_track_sequencer mts_checker u_mts_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
